>>> rtl/core/plqr_pkg.sv
package plqr_pkg;

	// Configuration port widths.
	localparam int CFG_INDEX_W = 4;
	localparam int CFG_DATA_W  = 20;
	localparam int GAIN_W      = 20;
	localparam int VOLT_W      = 15;

	// Register indexes on the configuration port.
	localparam logic [CFG_INDEX_W-1:0] REG_GAIN_ANGLE_SWINGING = 4'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_GAIN_RATE_SWINGING  = 4'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_GAIN_WHEEL_SWINGING = 4'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_GAIN_ANGLE_SETTLED  = 4'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_GAIN_RATE_SETTLED   = 4'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_GAIN_WHEEL_SETTLED  = 4'd5;
	localparam logic [CFG_INDEX_W-1:0] REG_VOLTAGE_CLAMP       = 4'd6;
	localparam logic [CFG_INDEX_W-1:0] REG_SWING_VOLTAGE       = 4'd7;

	// Register reset values.
	localparam logic [GAIN_W-1:0] RST_GAIN_ANGLE_SWINGING = 20'd204800;
	localparam logic [GAIN_W-1:0] RST_GAIN_RATE_SWINGING  = 20'd40960;
	localparam logic [GAIN_W-1:0] RST_GAIN_WHEEL_SWINGING = 20'd307;
	localparam logic [GAIN_W-1:0] RST_GAIN_ANGLE_SETTLED  = 20'd204800;
	localparam logic [GAIN_W-1:0] RST_GAIN_RATE_SETTLED   = 20'd15360;
	localparam logic [GAIN_W-1:0] RST_GAIN_WHEEL_SETTLED  = 20'd154;
	localparam logic [VOLT_W-1:0] RST_VOLTAGE_CLAMP       = 15'd28672;
	localparam logic [VOLT_W-1:0] RST_SWING_VOLTAGE       = 15'd6144;

	// Angle thresholds in Q.12 radians, compared against the 17-bit magnitude.
	localparam logic [16:0] SWING_THRESH    = 17'd2458;
	localparam logic [16:0] UNSETTLE_THRESH = 17'd205;

	// Hold time before the settled gain set takes over.
	localparam logic [31:0] STABLE_HOLD_MS = 32'd1000;

	// Queue between front and back.
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

	typedef struct packed {
		logic signed [15:0] tilt;
		logic signed [15:0] pendulum_rate;
		logic signed [23:0] wheel_velocity;
		logic        [31:0] now_ms;
	} in_item_t;

	typedef struct packed {
		logic signed [15:0] drive_voltage;
		logic               is_balanced;
		logic               is_swinging_up;
	} out_item_t;

	typedef struct packed {
		logic [GAIN_W-1:0] angle;
		logic [GAIN_W-1:0] rate;
		logic [GAIN_W-1:0] wheel;
	} gain_set_t;

	typedef struct packed {
		gain_set_t         swinging;
		gain_set_t         settled;
		logic [VOLT_W-1:0] voltage_clamp;
		logic [VOLT_W-1:0] swing_voltage;
	} cfg_regs_t;

	// One classified sample waiting for the back end.
	typedef struct packed {
		logic signed [15:0] angle;
		logic signed [15:0] rate;
		logic signed [23:0] wheel;
		gain_set_t          gains;
		logic               balanced;
		logic               swinging;
	} entry_t;

	// Handshake between the queue and its neighbors.
	typedef struct packed {
		logic full;
		logic empty;
	} queue_status_t;

endpackage

>>> rtl/core/pendulum_lqr_balance_controller_top.sv
// Path: an accepted sample passes the queue write, the product stage and the
// sum/clamp register before out_valid rises. Throughput: one sample per cycle;
// the front stalls only when the four-entry queue is full. Reset (arst_n low)
// clears the stability state, the queue and the pipeline valid bits, and loads
// every configuration register with its default; no clearing pass follows.
module pendulum_lqr_balance_controller_top (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  plqr_pkg::in_item_t                   in_data,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output plqr_pkg::out_item_t                  out_data,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [plqr_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [plqr_pkg::CFG_DATA_W-1:0]      cfg_data
);
	import plqr_pkg::*;

	cfg_regs_t     cfg_q;
	queue_status_t q_status;
	logic          push;
	entry_t        push_entry;
	logic          pop;
	entry_t        head;

	assign cfg_ready = 1'b1;

	// Configuration register file; unknown indexes are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.swinging.angle <= RST_GAIN_ANGLE_SWINGING;
			cfg_q.swinging.rate  <= RST_GAIN_RATE_SWINGING;
			cfg_q.swinging.wheel <= RST_GAIN_WHEEL_SWINGING;
			cfg_q.settled.angle  <= RST_GAIN_ANGLE_SETTLED;
			cfg_q.settled.rate   <= RST_GAIN_RATE_SETTLED;
			cfg_q.settled.wheel  <= RST_GAIN_WHEEL_SETTLED;
			cfg_q.voltage_clamp  <= RST_VOLTAGE_CLAMP;
			cfg_q.swing_voltage  <= RST_SWING_VOLTAGE;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_GAIN_ANGLE_SWINGING: cfg_q.swinging.angle <= cfg_data;
				REG_GAIN_RATE_SWINGING:  cfg_q.swinging.rate  <= cfg_data;
				REG_GAIN_WHEEL_SWINGING: cfg_q.swinging.wheel <= cfg_data;
				REG_GAIN_ANGLE_SETTLED:  cfg_q.settled.angle  <= cfg_data;
				REG_GAIN_RATE_SETTLED:   cfg_q.settled.rate   <= cfg_data;
				REG_GAIN_WHEEL_SETTLED:  cfg_q.settled.wheel  <= cfg_data;
				REG_VOLTAGE_CLAMP:       cfg_q.voltage_clamp  <= cfg_data[VOLT_W-1:0];
				REG_SWING_VOLTAGE:       cfg_q.swing_voltage  <= cfg_data[VOLT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Front end: classification and stability tracking.
	plqr_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.cfg        (cfg_q),
		.q_status   (q_status),
		.push       (push),
		.push_entry (push_entry)
	);

	// Queue between the two halves.
	plqr_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.status     (q_status)
	);

	// Back end: gain products, rounding and clamping.
	plqr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.q_status  (q_status),
		.pop       (pop),
		.cfg       (cfg_q),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

>>> rtl/core/plqr_front.sv
module plqr_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  plqr_pkg::in_item_t   in_data,
	input  plqr_pkg::cfg_regs_t  cfg,
	input  plqr_pkg::queue_status_t q_status,
	output logic                 push,
	output plqr_pkg::entry_t     push_entry
);
	import plqr_pkg::*;

	logic        stable_q;
	logic [31:0] last_unsettled_q;
	logic [16:0] mag;
	logic        swing;
	logic        unsettle;
	logic [31:0] elapsed;
	logic        stable_next;
	logic        accept;

	// Classify the sample by angle magnitude.
	always_comb begin
		if (in_data.tilt[15]) begin
			mag = 17'd0 - {in_data.tilt[15], in_data.tilt};
		end else begin
			mag = {1'b0, in_data.tilt};
		end
		swing    = (mag >= SWING_THRESH);
		unsettle = !swing && (mag >= UNSETTLE_THRESH);
		elapsed  = in_data.now_ms - last_unsettled_q;
		// A sample that restarts the timer forces the flag clear.
		stable_next = unsettle ? 1'b0 : (stable_q || (elapsed > STABLE_HOLD_MS));
	end

	assign in_ready = !q_status.full;
	assign accept   = in_valid && in_ready;
	assign push     = accept;

	// Build the queue entry with the gain set chosen for this sample.
	always_comb begin
		push_entry.angle    = in_data.tilt;
		push_entry.rate     = in_data.pendulum_rate;
		push_entry.wheel    = in_data.wheel_velocity;
		push_entry.swinging = swing;
		push_entry.balanced = !swing && stable_next;
		push_entry.gains    = stable_next ? cfg.settled : cfg.swinging;
	end

	// Stability state moves only on balancing samples.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stable_q         <= 1'b0;
			last_unsettled_q <= 32'd0;
		end else if (accept && !swing) begin
			stable_q <= stable_next;
			if (unsettle) begin
				last_unsettled_q <= in_data.now_ms;
			end
		end
	end

endmodule

>>> rtl/core/plqr_queue.sv
module plqr_queue (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	input  plqr_pkg::entry_t        push_entry,
	input  logic                    pop,
	output plqr_pkg::entry_t        head,
	output plqr_pkg::queue_status_t status
);
	import plqr_pkg::*;

	entry_t              mem_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wr_ptr_q;
	logic [QUEUE_AW-1:0] rd_ptr_q;
	logic [QUEUE_AW:0]   count_q;
	logic                do_push;
	logic                do_pop;

	assign status.full  = (count_q == QUEUE_AW'(0) + (QUEUE_AW+1)'(QUEUE_DEPTH));
	assign status.empty = (count_q == '0);
	assign do_push      = push && !status.full;
	assign do_pop       = pop && !status.empty;
	assign head         = mem_q[rd_ptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + QUEUE_AW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + QUEUE_AW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + (QUEUE_AW+1)'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - (QUEUE_AW+1)'(1);
			end
		end
	end

endmodule

>>> rtl/core/plqr_back.sv
module plqr_back (
	input  logic                    clk,
	input  logic                    arst_n,
	input  plqr_pkg::entry_t        head,
	input  plqr_pkg::queue_status_t q_status,
	output logic                    pop,
	input  plqr_pkg::cfg_regs_t     cfg,
	output logic                    out_valid,
	input  logic                    out_ready,
	output plqr_pkg::out_item_t     out_data
);
	import plqr_pkg::*;

	logic                v_s1;
	logic signed [36:0]  prod_a_s1;
	logic signed [36:0]  prod_r_s1;
	logic signed [44:0]  prod_w_s1;
	logic signed [15:0]  swing_u_s1;
	logic                balanced_s1;
	logic                swinging_s1;
	logic                v_s2;
	out_item_t           data_s2;
	logic                ready_s2;
	logic                ready_s1;
	logic signed [15:0]  swing_u;
	logic signed [15:0]  sv_pos;
	logic signed [46:0]  sum;
	logic signed [46:0]  rnd;
	logic signed [36:0]  u;
	logic signed [36:0]  lim;
	logic signed [15:0]  u_clamped;

	assign ready_s2  = !v_s2 || out_ready;
	assign ready_s1  = !v_s1 || ready_s2;
	assign pop       = ready_s1 && !q_status.empty;
	assign out_valid = v_s2;
	assign out_data  = data_s2;

	// Swing-up drive opposes the pendulum rate.
	always_comb begin
		sv_pos = $signed({1'b0, cfg.swing_voltage});
		if (!head.rate[15] && (head.rate != 16'sd0)) begin
			swing_u = 16'sd0 - sv_pos;
		end else if (head.rate[15]) begin
			swing_u = sv_pos;
		end else begin
			swing_u = 16'sd0;
		end
	end

	// Stage 1: the three gain products.
	always_ff @(posedge clk) begin
		if (pop) begin
			prod_a_s1   <= 37'($signed({1'b0, head.gains.angle}) * head.angle);
			prod_r_s1   <= 37'($signed({1'b0, head.gains.rate}) * head.rate);
			prod_w_s1   <= 45'($signed({1'b0, head.gains.wheel}) * head.wheel);
			swing_u_s1  <= swing_u;
			balanced_s1 <= head.balanced;
			swinging_s1 <= head.swinging;
		end
	end

	// Sum, round to nearest with ties upward, then clamp.
	always_comb begin
		sum = 47'(prod_a_s1) + 47'(prod_r_s1) + 47'(prod_w_s1);
		rnd = sum + 47'sd512;
		u   = rnd[46:10];
		lim = $signed({22'd0, cfg.voltage_clamp});
		if (u > lim) begin
			u_clamped = lim[15:0];
		end else if (u < -lim) begin
			u_clamped = 16'(-lim);
		end else begin
			u_clamped = u[15:0];
		end
	end

	// Stage 2: output register.
	always_ff @(posedge clk) begin
		if (v_s1 && ready_s2) begin
			data_s2.drive_voltage  <= swinging_s1 ? swing_u_s1 : u_clamped;
			data_s2.is_balanced    <= balanced_s1;
			data_s2.is_swinging_up <= swinging_s1;
		end
	end

	// Stage valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (ready_s1) begin
				v_s1 <= pop;
			end
			if (ready_s2) begin
				v_s2 <= v_s1;
			end
		end
	end

endmodule

>>> bench/pendulum_lqr_balance_controller_top_test.sv
`timescale 1ns / 1ps

module pendulum_lqr_balance_controller_top_test;
	import plqr_pkg::*;

	// Angle thresholds in Q.12 radians and the settling hold time in ms.
	localparam int          SWING_LIMIT   = 2458;
	localparam int          DISTURB_LIMIT = 205;
	localparam logic [31:0] HOLD_MS       = 32'd1000;

	localparam int RANDOM_PHASES = 8;
	localparam int PHASE_SAMPLES = 200;

	// Register indexes past the last defined register are outside the map.
	localparam logic [CFG_INDEX_W-1:0] FIRST_UNUSED_INDEX = REG_SWING_VOLTAGE + 1'b1;

	typedef struct packed {
		in_item_t  stim;
		logic      has_want;
		out_item_t want;
	} stim_row_t;

	logic                   clk       = 1'b0;
	logic                   arst_n    = 1'b0;
	logic                   in_valid  = 1'b0;
	logic                   in_ready;
	in_item_t               in_data   = '0;
	logic                   out_valid;
	logic                   out_ready = 1'b0;
	out_item_t              out_data;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data  = '0;

	// Our copy of the configuration registers and the stability state.
	logic [GAIN_W-1:0] ka_swing   = RST_GAIN_ANGLE_SWINGING;
	logic [GAIN_W-1:0] kr_swing   = RST_GAIN_RATE_SWINGING;
	logic [GAIN_W-1:0] kw_swing   = RST_GAIN_WHEEL_SWINGING;
	logic [GAIN_W-1:0] ka_settled = RST_GAIN_ANGLE_SETTLED;
	logic [GAIN_W-1:0] kr_settled = RST_GAIN_RATE_SETTLED;
	logic [GAIN_W-1:0] kw_settled = RST_GAIN_WHEEL_SETTLED;
	logic [VOLT_W-1:0] clamp_level = RST_VOLTAGE_CLAMP;
	logic [VOLT_W-1:0] swing_level = RST_SWING_VOLTAGE;
	logic              settled_flag = 1'b0;
	logic [31:0]       last_disturbed_ms = '0;

	out_item_t pending_drives[$];
	stim_row_t directed_rows[$];

	// Random stimulus shaping: episodes of calm or disturbed motion.
	logic [31:0] clock_ms      = '0;
	int          episode_left  = 0;
	int          episode_kind  = 0;

	int samples_sent   = 0;
	int results_seen   = 0;
	int swing_results  = 0;
	int settled_results = 0;
	int writes_done    = 0;
	int mismatches     = 0;
	int ready_run      = 0;

	pendulum_lqr_balance_controller_top uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("TEST FAILED");
		$finish;
	end

	// Computes the drive voltage for one accepted sample and advances the
	// stability state the same way the block does.
	function automatic out_item_t predict_drive(input in_item_t s);
		longint      angle, rate, wheel, magnitude, ka, kr, kw, acc, volts, limit;
		logic [31:0] elapsed;
		out_item_t   r;
		angle = $signed(s.tilt);
		rate = $signed(s.pendulum_rate);
		wheel = $signed(s.wheel_velocity);
		magnitude = (angle < 0) ? -angle : angle;
		r = '0;
		if (magnitude >= SWING_LIMIT) begin
			// Swing-up leaves the stability state untouched.
			r.is_swinging_up = 1'b1;
			limit = swing_level;
			if (rate > 0)
				volts = -limit;
			else if (rate < 0)
				volts = limit;
			else
				volts = 0;
		end else begin
			if (magnitude >= DISTURB_LIMIT) begin
				last_disturbed_ms = s.now_ms;
				settled_flag = 1'b0;
			end
			elapsed = s.now_ms - last_disturbed_ms;
			if (elapsed > HOLD_MS)
				settled_flag = 1'b1;
			if (settled_flag) begin
				ka = ka_settled;
				kr = kr_settled;
				kw = kw_settled;
			end else begin
				ka = ka_swing;
				kr = kr_swing;
				kw = kw_swing;
			end
			r.is_balanced = settled_flag;
			// Q.22 sum, rounded to Q.12 with ties going up, then clamped.
			acc = ka * angle + kr * rate + kw * wheel;
			volts = (acc + 512) >>> 10;
			limit = clamp_level;
			if (volts > limit)
				volts = limit;
			if (volts < -limit)
				volts = -limit;
		end
		r.drive_voltage = volts[15:0];
		return r;
	endfunction

	// Builds the next random sample: mostly coherent motion with rising time,
	// some disturbed stretches, and some plain noise.
	function automatic in_item_t next_random_sample();
		in_item_t s;
		int       pick;
		int       a;
		int       magnitude;
		if (episode_left == 0) begin
			episode_kind = $urandom_range(0, 3);
			episode_left = $urandom_range(10, 60);
		end
		episode_left--;

		s.pendulum_rate = 16'($urandom);
		if ($urandom_range(0, 3) == 0)
			s.pendulum_rate = s.pendulum_rate >>> $urandom_range(4, 15);
		s.wheel_velocity = 24'($urandom);
		s.wheel_velocity = s.wheel_velocity >>> $urandom_range(0, 23);

		case (episode_kind)
			0, 1: clock_ms += $urandom_range(0, 60);
			2: clock_ms += $urandom_range(0, 400);
			default: begin
				if ($urandom_range(0, 1) == 0)
					clock_ms = $urandom;
				else
					clock_ms += $urandom_range(0, 2000);
			end
		endcase
		s.now_ms = clock_ms;

		pick = $urandom_range(0, 99);
		if (episode_kind <= 1)
			pick = (pick < 95) ? 0 : 40;
		else if (episode_kind == 3)
			pick = pick * 2 / 3 + 33;

		if (pick < 40) begin
			// Inside the settled band.
			a = $urandom_range(0, 2 * (DISTURB_LIMIT - 1));
			a = a - (DISTURB_LIMIT - 1);
		end else if (pick < 70) begin
			// Disturbed but still under LQR control; multiples of 512 hit rounding ties.
			magnitude = $urandom_range(DISTURB_LIMIT, SWING_LIMIT - 1);
			if ($urandom_range(0, 3) == 0)
				magnitude = 512 * $urandom_range(1, 4);
			a = ($urandom_range(0, 1) == 0) ? magnitude : -magnitude;
		end else if (pick < 95) begin
			// Swing-up range, with a standing pendulum now and then.
			magnitude = $urandom_range(SWING_LIMIT, 32768);
			a = ($urandom_range(0, 1) == 0) ? magnitude : -magnitude;
			if ($urandom_range(0, 7) == 0)
				s.pendulum_rate = '0;
		end else begin
			a = $urandom;
		end
		s.tilt = a[15:0];
		return s;
	endfunction

	task automatic add_row(input int angle, input int rate, input int wheel,
			input logic [31:0] stamp, input logic has_want, input int volts,
			input logic balanced, input logic swinging);
		stim_row_t row;
		row.stim.tilt = angle[15:0];
		row.stim.pendulum_rate = rate[15:0];
		row.stim.wheel_velocity = wheel[23:0];
		row.stim.now_ms = stamp;
		row.has_want = has_want;
		row.want.drive_voltage = volts[15:0];
		row.want.is_balanced = balanced;
		row.want.is_swinging_up = swinging;
		directed_rows.push_back(row);
	endtask

	// Presents one sample and waits for its transaction; the expectation is
	// queued at the accepting edge.
	task automatic send_sample(input in_item_t s, input logic use_typed,
			input out_item_t typed_want);
		out_item_t want;
		in_valid <= 1'b1;
		in_data <= s;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		want = predict_drive(s);
		if (use_typed)
			want = typed_want;
		pending_drives.push_back(want);
		samples_sent++;
	endtask

	task automatic pause_sender(input int cycles);
		in_valid <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	task automatic wait_for_results();
		while (pending_drives.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	// One register write transaction; valid stays high for a following write.
	task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			REG_GAIN_ANGLE_SWINGING: ka_swing = value;
			REG_GAIN_RATE_SWINGING: kr_swing = value;
			REG_GAIN_WHEEL_SWINGING: kw_swing = value;
			REG_GAIN_ANGLE_SETTLED: ka_settled = value;
			REG_GAIN_RATE_SETTLED: kr_settled = value;
			REG_GAIN_WHEEL_SETTLED: kw_settled = value;
			REG_VOLTAGE_CLAMP: clamp_level = value[VOLT_W-1:0];
			REG_SWING_VOLTAGE: swing_level = value[VOLT_W-1:0];
			default: ;
		endcase
		writes_done++;
	endtask

	// Loads the register setting for one random phase.
	task automatic program_phase(input int phase);
		int r;
		case (phase)
			1: begin
				for (r = 0; r <= REG_SWING_VOLTAGE; r++)
					write_register(r[CFG_INDEX_W-1:0], '1);
				write_register(CFG_INDEX_W'($urandom_range(FIRST_UNUSED_INDEX,
					2 ** CFG_INDEX_W - 1)), CFG_DATA_W'($urandom));
			end
			2: begin
				for (r = 0; r <= REG_SWING_VOLTAGE; r++)
					write_register(r[CFG_INDEX_W-1:0], '0);
			end
			3: begin
				// Unit angle gain only, so the output is the angle divided by 1024 and rounded.
				write_register(REG_GAIN_ANGLE_SWINGING, 20'd1);
				write_register(REG_GAIN_RATE_SWINGING, '0);
				write_register(REG_GAIN_WHEEL_SWINGING, '0);
				write_register(REG_GAIN_ANGLE_SETTLED, 20'd1);
				write_register(REG_GAIN_RATE_SETTLED, '0);
				write_register(REG_GAIN_WHEEL_SETTLED, '0);
				write_register(REG_VOLTAGE_CLAMP, 20'h07FFF);
				write_register(REG_SWING_VOLTAGE, 20'd1);
			end
			4: begin
				// Defaults again; the voltage writes carry junk above bit 14.
				write_register(REG_GAIN_ANGLE_SWINGING, RST_GAIN_ANGLE_SWINGING);
				write_register(REG_GAIN_RATE_SWINGING, RST_GAIN_RATE_SWINGING);
				write_register(REG_GAIN_WHEEL_SWINGING, RST_GAIN_WHEEL_SWINGING);
				write_register(REG_GAIN_ANGLE_SETTLED, RST_GAIN_ANGLE_SETTLED);
				write_register(REG_GAIN_RATE_SETTLED, RST_GAIN_RATE_SETTLED);
				write_register(REG_GAIN_WHEEL_SETTLED, RST_GAIN_WHEEL_SETTLED);
				write_register(REG_VOLTAGE_CLAMP, {5'($urandom_range(1, 31)), RST_VOLTAGE_CLAMP});
				write_register(REG_SWING_VOLTAGE, {5'($urandom_range(1, 31)), RST_SWING_VOLTAGE});
			end
			default: begin
				for (r = 0; r <= REG_SWING_VOLTAGE; r++)
					write_register(r[CFG_INDEX_W-1:0],
						CFG_DATA_W'($urandom >> $urandom_range(0, 31)));
				write_register(CFG_INDEX_W'($urandom_range(FIRST_UNUSED_INDEX,
					2 ** CFG_INDEX_W - 1)), CFG_DATA_W'($urandom));
			end
		endcase
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Receiver: alternating runs of ready and stall, with an occasional long ready run.
	always @(posedge clk) begin
		if (ready_run == 0) begin
			if (out_ready) begin
				out_ready <= 1'b0;
				ready_run <= $urandom_range(1, 6);
			end else begin
				out_ready <= 1'b1;
				ready_run <= ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(1, 20);
			end
		end else begin
			ready_run <= ready_run - 1;
		end
	end

	// Result checker: each output transaction against the oldest expectation.
	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			if (out_data.is_swinging_up)
				swing_results++;
			if (out_data.is_balanced)
				settled_results++;
			if (pending_drives.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual %0d/%0b/%0b", $time,
					out_data.drive_voltage, out_data.is_balanced, out_data.is_swinging_up);
				mismatches++;
			end else begin
				want = pending_drives.pop_front();
				if (out_data.drive_voltage !== want.drive_voltage) begin
					$display("%0t: drive_voltage expected %0d, actual %0d", $time,
						want.drive_voltage, out_data.drive_voltage);
					mismatches++;
				end
				if (out_data.is_balanced !== want.is_balanced) begin
					$display("%0t: is_balanced expected %0b, actual %0b", $time,
						want.is_balanced, out_data.is_balanced);
					mismatches++;
				end
				if (out_data.is_swinging_up !== want.is_swinging_up) begin
					$display("%0t: is_swinging_up expected %0b, actual %0b", $time,
						want.is_swinging_up, out_data.is_swinging_up);
					mismatches++;
				end
			end
		end
	end

	// Main sequence: reset, directed table, then random phases under varied settings.
	initial begin
		int phase;
		int sent;
		int burst;
		int k;

		// Directed rows; expected values are typed where they are obvious.
		add_row(0, 0, 0, 32'd0, 1'b1, 0, 1'b0, 1'b0);
		add_row(2458, 1, 0, 32'd0, 1'b1, -6144, 1'b0, 1'b1);
		add_row(-2458, -1, 0, 32'd0, 1'b1, 6144, 1'b0, 1'b1);
		add_row(32767, 0, 0, 32'd0, 1'b1, 0, 1'b0, 1'b1);
		add_row(-32768, -32768, -8388608, 32'd0, 1'b1, 6144, 1'b0, 1'b1);
		add_row(-32768, 32767, 8388607, 32'd0, 1'b1, -6144, 1'b0, 1'b1);
		add_row(2457, 0, 0, 32'd0, 1'b1, 28672, 1'b0, 1'b0);
		add_row(-2457, 0, 0, 32'd0, 1'b1, -28672, 1'b0, 1'b0);
		// Timer restart exactly at the threshold, then the hold boundary.
		add_row(205, 0, 0, 32'd5, 1'b0, 0, 1'b0, 1'b0);
		add_row(204, 0, 0, 32'd1005, 1'b0, 0, 1'b0, 1'b0);
		add_row(204, 0, 0, 32'd1006, 1'b0, 0, 1'b0, 1'b0);
		// Swing-up while settled must not disturb the settled state.
		add_row(3000, 5, 0, 32'd1010, 1'b0, 0, 1'b0, 1'b0);
		add_row(0, 32767, 8388607, 32'd1020, 1'b0, 0, 1'b0, 1'b0);
		add_row(0, -32768, -8388608, 32'd1030, 1'b0, 0, 1'b0, 1'b0);
		add_row(1, 1, -1, 32'd1040, 1'b0, 0, 1'b0, 1'b0);
		add_row(-205, 0, 0, 32'd1050, 1'b0, 0, 1'b0, 1'b0);
		add_row(-204, 0, 0, 32'd2051, 1'b0, 0, 1'b0, 1'b0);
		// Millisecond counter wrapping between restart and settling.
		add_row(300, 0, 0, 32'hFFFF_FF00, 1'b0, 0, 1'b0, 1'b0);
		add_row(0, 0, 0, 32'h0000_0100, 1'b0, 0, 1'b0, 1'b0);
		add_row(0, 0, 0, 32'h0000_02F0, 1'b0, 0, 1'b0, 1'b0);
		add_row(-1, -1, 1, 32'h0000_0300, 1'b0, 0, 1'b0, 1'b0);
		add_row(0, 0, 0, 32'hFFFF_FFFF, 1'b0, 0, 1'b0, 1'b0);

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			send_sample(directed_rows[i].stim, directed_rows[i].has_want, directed_rows[i].want);
			if (i == directed_rows.size() - 1 || $urandom_range(0, 3) == 0)
				pause_sender($urandom_range(1, 4));
		end

		// Each phase starts from an idle block, so the registers can change safely.
		for (phase = 0; phase < RANDOM_PHASES; phase++) begin
			wait_for_results();
			if (phase > 0)
				program_phase(phase);
			sent = 0;
			while (sent < PHASE_SAMPLES) begin
				burst = ($urandom_range(0, 7) == 0) ? 80 : $urandom_range(1, 30);
				if (burst > PHASE_SAMPLES - sent)
					burst = PHASE_SAMPLES - sent;
				for (k = 0; k < burst; k++) begin
					send_sample(next_random_sample(), 1'b0, '0);
					sent++;
				end
				pause_sender($urandom_range(1, 8));
			end
		end

		wait_for_results();
		repeat (8) @(posedge clk);

		$display("Run covered %0d samples over %0d register settings with %0d register writes.",
			samples_sent, RANDOM_PHASES, writes_done);
		$display("Checked %0d results: %0d swing-up, %0d on settled gains, %0d mismatches.",
			results_seen, swing_results, settled_results, mismatches);
		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
